### rtl/smc_pkg.sv
// smc_pkg: shared constants for the stack machine core.
// Command codes, opcodes and fault codes. No dependencies.
package smc_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_EXEC    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [7:0] OP_HALT  = 8'd0;
  localparam logic [7:0] OP_PUSH  = 8'd1;
  localparam logic [7:0] OP_LOAD  = 8'd2;
  localparam logic [7:0] OP_STORE = 8'd3;
  localparam logic [7:0] OP_ADD   = 8'd4;
  localparam logic [7:0] OP_SUB   = 8'd5;
  localparam logic [7:0] OP_MUL   = 8'd6;
  localparam logic [7:0] OP_DIV   = 8'd7;
  localparam logic [7:0] OP_PRINT = 8'd8;
  localparam logic [7:0] OP_JZ    = 8'd9;
  localparam logic [7:0] OP_JMP   = 8'd10;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_OPCODE = 2'd1;
  localparam logic [1:0] FAULT_DIV0   = 2'd2;

  typedef logic [31:0] word_t;

endpackage

### rtl/smc_if.sv
// smc_if: valid/ready channel interfaces for command input and status output.
// Depends on smc_pkg for the word type.
interface smc_in_if import smc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [9:0]  word_index;
  word_t       load_data;
  modport source (output valid, cmd, word_index, load_data, input ready);
  modport sink   (input valid, cmd, word_index, load_data, output ready);
endinterface

interface smc_out_if import smc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        print_valid;
  word_t       print_value;
  logic        halted;
  logic [1:0]  fault_code;
  modport source (output valid, print_valid, print_value, halted, fault_code, input ready);
  modport sink   (input valid, print_valid, print_value, halted, fault_code, output ready);
endinterface

### rtl/stack_machine_core.sv
// stack_machine_core: byte-serial stack processor over one shared byte RAM.
// DIV waits on the divider; an address at or above the memory size takes an
// extra wrap step. One command in flight: a new command is taken only in idle.
// Memory is reached one byte per access.
// Reset (sync, rst high) clears pointers, stop/fault and the output valid.
module stack_machine_core import smc_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  smc_in_if.sink    req,
  smc_out_if.source rsp
);

  localparam int MEM_BYTES = MEM_WORDS * 4;
  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [31:0] MB_W = 32'(MEM_BYTES);
  localparam logic [AW-1:0] MB_LAST = AW'(MEM_BYTES - 1);
  localparam logic [AW-1:0] MB_M4 = AW'(MEM_BYTES - 4);
  // reciprocal of the memory size: floor(x * RECIP >> SH) == x / MEM_BYTES
  localparam int SH = 32 + AW;
  localparam logic [32:0] RECIP =
    33'(((64'd1 << SH) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES));

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_FETCH    = 5'd1;
  localparam logic [4:0] S_FETCH_W  = 5'd2;
  localparam logic [4:0] S_DECODE   = 5'd3;
  localparam logic [4:0] S_RD       = 5'd4;
  localparam logic [4:0] S_RD_W     = 5'd5;
  localparam logic [4:0] S_WR       = 5'd6;
  localparam logic [4:0] S_PUSH_IMM = 5'd7;
  localparam logic [4:0] S_PUSH     = 5'd8;
  localparam logic [4:0] S_POPB_D   = 5'd9;
  localparam logic [4:0] S_POPA_D   = 5'd10;
  localparam logic [4:0] S_EXEC     = 5'd11;
  localparam logic [4:0] S_WRAP     = 5'd12;
  localparam logic [4:0] S_WRAP_W   = 5'd13;
  localparam logic [4:0] S_LOAD_D   = 5'd14;
  localparam logic [4:0] S_JUMP_A   = 5'd15;
  localparam logic [4:0] S_DIV_W    = 5'd16;
  localparam logic [4:0] S_FINISH   = 5'd17;

  logic [4:0]    state, rret, wret;
  logic [AW-1:0] ip, sp, ptr;
  logic          stopped;
  logic [1:0]    fault;
  logic [7:0]    op;
  word_t         a, b, acc, wbuf, wv;
  logic [1:0]    k;
  logic          neg;
  logic          pv;
  word_t         pval;
  logic [64:0]   wprod;
  word_t         wq, wrem;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          div_start, div_done;
  word_t         div_n, div_d, div_q, div_r;

  function automatic logic [AW-1:0] inc1(input logic [AW-1:0] p);
    return (p == MB_LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec4(input logic [AW-1:0] p);
    return (p < AW'(4)) ? p + MB_M4 : p - AW'(4);
  endfunction

  assign ram_we    = (state == S_WR);
  assign ram_re    = (state == S_RD) || (state == S_FETCH);
  assign ram_raddr = (state == S_FETCH) ? ip : ptr;

  smc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (wbuf[8*k +: 8]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // address wrap: quotient from the registered product, then one subtract
  assign wq   = 32'(wprod >> SH);
  assign wrem = wv - wq * MB_W;

  assign div_start = (state == S_EXEC) && (op == OP_DIV) && (b != '0);
  assign div_n     = a[31] ? -a : a;
  assign div_d     = b[31] ? -b : b;

  smc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ip        <= '0;
      sp        <= '0;
      stopped   <= 1'b0;
      fault     <= FAULT_NONE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            pv   <= 1'b0;
            pval <= '0;
            case (req.cmd)
              CMD_LOAD: begin
                wbuf  <= req.load_data;
                wv    <= {20'd0, req.word_index, 2'b00};
                k     <= '0;
                rret  <= S_FINISH;
                wret  <= S_WR;
                state <= S_WRAP;
              end
              CMD_EXEC: begin
                state <= stopped ? S_FINISH : S_FETCH;
              end
              CMD_RESTART: begin
                ip      <= '0;
                sp      <= '0;
                stopped <= 1'b0;
                fault   <= FAULT_NONE;
                state   <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_FETCH: state <= S_FETCH_W;
        S_FETCH_W: begin
          op    <= ram_rdata;
          ip    <= inc1(ip);
          state <= S_DECODE;
        end
        S_DECODE: begin
          k <= '0;
          case (op)
            OP_HALT: begin
              stopped <= 1'b1;
              state   <= S_FINISH;
            end
            OP_PUSH: begin
              ptr   <= ip;
              rret  <= S_PUSH_IMM;
              state <= S_RD;
            end
            OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_PRINT, OP_JZ,
            OP_JMP: begin
              ptr   <= sp;
              rret  <= S_POPB_D;
              state <= S_RD;
            end
            default: begin
              stopped <= 1'b1;
              fault   <= FAULT_OPCODE;
              state   <= S_FINISH;
            end
          endcase
        end
        S_RD: state <= S_RD_W;
        S_RD_W: begin
          acc[8*k +: 8] <= ram_rdata;
          ptr <= inc1(ptr);
          k   <= k + 2'd1;
          state <= (k == 2'd3) ? rret : S_RD;
        end
        S_WR: begin
          ptr <= inc1(ptr);
          k   <= k + 2'd1;
          if (k == 2'd3) state <= rret;
        end
        S_PUSH_IMM: begin
          ip    <= ptr;
          wbuf  <= acc;
          state <= S_PUSH;
        end
        S_PUSH: begin
          sp    <= dec4(sp);
          ptr   <= dec4(sp);
          k     <= '0;
          rret  <= S_FINISH;
          state <= S_WR;
        end
        S_POPB_D: begin
          // ptr already sits four bytes above the old top (wrapped)
          b  <= acc;
          sp <= ptr;
          if (op == OP_LOAD || op == OP_PRINT || op == OP_JMP) begin
            state <= S_EXEC;
          end else begin
            k     <= '0;
            rret  <= S_POPA_D;
            state <= S_RD;
          end
        end
        S_POPA_D: begin
          a     <= acc;
          sp    <= ptr;
          state <= S_EXEC;
        end
        S_EXEC: begin
          k <= '0;
          case (op)
            OP_LOAD: begin
              wv    <= b;
              rret  <= S_LOAD_D;
              wret  <= S_RD;
              state <= S_WRAP;
            end
            OP_STORE: begin
              wbuf  <= b;
              wv    <= a;
              rret  <= S_FINISH;
              wret  <= S_WR;
              state <= S_WRAP;
            end
            OP_ADD: begin
              wbuf  <= a + b;
              state <= S_PUSH;
            end
            OP_SUB: begin
              wbuf  <= a - b;
              state <= S_PUSH;
            end
            OP_MUL: begin
              wbuf  <= a * b;
              state <= S_PUSH;
            end
            OP_DIV: begin
              if (b == '0) begin
                stopped <= 1'b1;
                fault   <= FAULT_DIV0;
                state   <= S_FINISH;
              end else begin
                neg   <= a[31] ^ b[31];
                state <= S_DIV_W;
              end
            end
            OP_PRINT: begin
              pv    <= 1'b1;
              pval  <= b;
              state <= S_FINISH;
            end
            OP_JZ: begin
              if (a == '0) begin
                wv    <= b;
                wret  <= S_JUMP_A;
                state <= S_WRAP;
              end else begin
                state <= S_FINISH;
              end
            end
            OP_JMP: begin
              wv    <= b;
              wret  <= S_JUMP_A;
              state <= S_WRAP;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_WRAP: begin
          if (wv < MB_W) begin
            ptr   <= wv[AW-1:0];
            state <= wret;
          end else begin
            wprod <= 65'(wv) * 65'(RECIP);
            state <= S_WRAP_W;
          end
        end
        S_WRAP_W: begin
          ptr   <= wrem[AW-1:0];
          state <= wret;
        end
        S_LOAD_D: begin
          wbuf  <= acc;
          state <= S_PUSH;
        end
        S_JUMP_A: begin
          ip    <= ptr;
          state <= S_FINISH;
        end
        S_DIV_W: begin
          if (div_done) begin
            wbuf  <= neg ? -div_q : div_q;
            state <= S_PUSH;
          end
        end
        S_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.print_valid <= pv;
            rsp.print_value <= pval;
            rsp.halted      <= stopped;
            rsp.fault_code  <= fault;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (32'(ip) < MB_W) && (32'(sp) < MB_W))
    else $error("ip or sp outside memory");

  a_fault_stops: assert property (@(posedge clk) disable iff (rst)
    (fault != FAULT_NONE) |-> stopped)
    else $error("fault without stop");

  a_div_done_ctx: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_W))
    else $error("divider finished outside its wait state");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_FINISH)
    else $error("response raised outside finish");
`endif

endmodule

### rtl/smc_ram.sv
// smc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module smc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/smc_div.sv
// smc_div: unsigned 32-bit restoring divider, one quotient bit per cycle.
// Depends on smc_pkg for the word type.
module smc_div import smc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t quotient,
  output word_t remainder
);

  logic        busy;
  logic [4:0]  cnt;
  word_t       dvs;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {remainder, quotient[31]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        remainder <= '0;
        quotient  <= dividend;
        dvs       <= divisor;
      end else if (busy) begin
        if (!diff[32]) begin
          remainder <= diff[31:0];
          quotient  <= {quotient[30:0], 1'b1};
        end else begin
          remainder <= shifted[31:0];
          quotient  <= {quotient[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
